>>> rtl/core/bpr_pkg.sv
// shared types, constants and helpers for the byte pattern replace block
package bpr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int LEN_W = 4;

  typedef logic [7:0] byte_t;
  typedef logic [LEN_W-1:0] len_t;
  typedef logic [MAX_PATTERN-1:0][7:0] win_t;

  typedef enum logic [1:0] {
    REG_PATTERN_BYTES,
    REG_PATTERN_LEN,
    REG_REPL_BYTES,
    REG_REPL_LEN
  } cfg_reg_t;

  // one request's worth of results, oldest byte in entry 0
  typedef struct packed {
    win_t bytes;
    len_t cnt;
    logic rep;
    logic eob;
  } burst_t;

  function automatic len_t eff_len(input len_t v);
    if (v > len_t'(MAX_PATTERN)) begin
      return len_t'(MAX_PATTERN);
    end
    return v;
  endfunction

endpackage

>>> rtl/core/byte_pattern_replace.sv
// top level of the streaming find-and-replace block
// usage:
//   input stream s_*: one byte per request, s_tlast on the final byte of a buffer
//   output stream m_*: patched bytes, m_tuser high on replacement bytes,
//   m_tlast on the final output byte of a buffer
//   cfg_we/cfg_index/cfg_data: register writes, only while the block is idle;
//   a pattern length write empties the match window
// latency: results of a request are presented on the cycle after it is taken
// throughput: one input byte per cycle while each byte gives at most one
//   result and m_tready stays high; a request giving more results holds the
//   output burst register, and input is taken again in the cycle its last result leaves
// bytes that only extend a partial match give no result until the match is
//   decided or the buffer ends
// reset: window empty, output burst empty, pattern length 0 (pass-through),
//   replacement length 1
// receiver stall: the burst register holds, and input is refused until it
//   drains to its final result
module byte_pattern_replace (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // data_byte
  input  logic              s_tlast,   // end_of_buffer
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // out_byte
  output logic              m_tuser,   // from_replacement
  output logic              m_tlast,   // last
  input  logic              cfg_we,
  input  bpr_pkg::cfg_reg_t cfg_index,
  input  logic [63:0]       cfg_data
);
  import bpr_pkg::*;

  win_t   pat_bytes;
  win_t   rep_bytes;
  len_t   pat_len_reg;
  len_t   rep_len_reg;
  len_t   pat_len;
  len_t   rep_len;
  win_t   win;
  len_t   win_count;
  win_t   win_next;
  len_t   win_count_next;
  burst_t burst;
  burst_t step_burst;
  logic   s_accept;
  logic   m_accept;
  logic   pat_len_write;

  assign pat_len = eff_len(pat_len_reg);
  assign rep_len = eff_len(rep_len_reg);

  assign m_tvalid = (burst.cnt != '0);
  assign m_tdata  = burst.bytes[0];
  assign m_tuser  = burst.rep;
  assign m_tlast  = burst.eob && (burst.cnt == len_t'(1));
  assign m_accept = m_tvalid && m_tready;
  assign s_tready = (burst.cnt == '0) || ((burst.cnt == len_t'(1)) && m_tready);
  assign s_accept = s_tvalid && s_tready;
  assign pat_len_write = cfg_we && (cfg_index == REG_PATTERN_LEN);

  bpr_step u_step (
    .win            (win),
    .win_count      (win_count),
    .data_byte      (s_tdata),
    .end_of_buffer  (s_tlast),
    .pat_len        (pat_len),
    .rep_len        (rep_len),
    .pat_bytes      (pat_bytes),
    .rep_bytes      (rep_bytes),
    .burst          (step_burst),
    .win_next       (win_next),
    .win_count_next (win_count_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_bytes   <= '0;
      pat_len_reg <= '0;
      rep_bytes   <= '0;
      rep_len_reg <= len_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PATTERN_BYTES: pat_bytes   <= cfg_data;
        REG_PATTERN_LEN:   pat_len_reg <= cfg_data[LEN_W-1:0];
        REG_REPL_BYTES:    rep_bytes   <= cfg_data;
        REG_REPL_LEN:      rep_len_reg <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_count <= '0;
    end else if (pat_len_write) begin
      win_count <= '0;
    end else if (s_accept) begin
      win_count <= win_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      win <= win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst.cnt <= '0;
    end else if (s_accept) begin
      burst <= step_burst;
    end else if (m_accept) begin
      burst.cnt <= burst.cnt - len_t'(1);
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        burst.bytes[i] <= burst.bytes[i+1];
      end
    end
  end

`ifndef SYNTHESIS
  a_window_below_pattern: assert property (@(posedge clk) disable iff (rst)
    (pat_len != '0) |-> (win_count < pat_len))
    else $error("window holds a full pattern length");

  a_pattern_len_clears: assert property (@(posedge clk) disable iff (rst)
    pat_len_write |=> (win_count == '0))
    else $error("window not emptied by pattern length write");

  a_pass_emits_all: assert property (@(posedge clk) disable iff (rst)
    (s_accept && !pat_len_write && ((pat_len == '0) || (rep_len == '0)))
    |=> (burst.cnt == $past(win_count) + len_t'(1)) && (win_count == '0))
    else $error("pass-through did not flush the window");

  a_rep_burst_len: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (burst.cnt <= len_t'(MAX_PATTERN)) && (burst.cnt != '0))
    else $error("replacement burst length out of range");
`endif

endmodule

>>> rtl/core/bpr_step.sv
// combinational step: window append, pattern compare and result burst for one request
module bpr_step (
  input  bpr_pkg::win_t   win,
  input  bpr_pkg::len_t   win_count,
  input  bpr_pkg::byte_t  data_byte,
  input  logic            end_of_buffer,
  input  bpr_pkg::len_t   pat_len,
  input  bpr_pkg::len_t   rep_len,
  input  bpr_pkg::win_t   pat_bytes,
  input  bpr_pkg::win_t   rep_bytes,
  output bpr_pkg::burst_t burst,
  output bpr_pkg::win_t   win_next,
  output bpr_pkg::len_t   win_count_next
);
  import bpr_pkg::*;

  win_t app;
  len_t app_count;
  logic pass;
  logic full;
  logic hit;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      app[i] = (LEN_W'(i) == win_count) ? data_byte : win[i];
    end
    app_count = win_count + len_t'(1);
    pass = (pat_len == '0) || (rep_len == '0);
    full = (app_count == pat_len);
    hit = full;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((LEN_W'(i) < pat_len) && (app[i] != pat_bytes[i])) begin
        hit = 1'b0;
      end
    end

    burst.eob = end_of_buffer;
    burst.rep = 1'b0;
    burst.bytes = app;
    burst.cnt = '0;
    win_next = app;
    win_count_next = app_count;

    if (pass || (end_of_buffer && !(full && hit))) begin
      // emit everything held plus the new byte
      burst.cnt = app_count;
      win_count_next = '0;
    end else if (full && hit) begin
      burst.bytes = rep_bytes;
      burst.rep = 1'b1;
      burst.cnt = rep_len;
      win_count_next = '0;
    end else if (full) begin
      // oldest byte leaves, the rest slide down
      burst.cnt = len_t'(1);
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
        win_next[i] = app[i+1];
      end
      win_next[MAX_PATTERN-1] = app[MAX_PATTERN-1];
      win_count_next = app_count - len_t'(1);
    end
  end

endmodule
